@@ hw/rtl/rsg_pkg.sv @@
// Shared types and constants for the random shape generator.
// Holds the controller/datapath command and status structs, LCG constants,
// register indexes, field codes and the RGB565 palette. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsg_pkg;

    // LCG constants, s' = s * LCG_MUL + LCG_INC (mod 2^32)
    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_INC = 32'd1013904223;

    // Remainder unit: one quotient bit per cycle over the 32-bit value
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Payload widths
    localparam int unsigned SEED_W  = 32;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd3;

    // Field codes, in generator order
    localparam logic [2:0] FLD_KIND   = 3'd0;
    localparam logic [2:0] FLD_SIZE   = 3'd1;
    localparam logic [2:0] FLD_CX     = 3'd2;
    localparam logic [2:0] FLD_CY     = 3'd3;
    localparam logic [2:0] FLD_COLOUR = 3'd4;

    // Span of the kind field
    localparam logic [9:0] KIND_SPAN = 10'd3;

    // Controller -> datapath commands
    typedef struct packed {
        logic       load;   // load seed, capture config check
        logic       step;   // advance generator, start remainder
        logic       shift;  // one remainder iteration
        logic       store;  // latch finished field
        logic       emit;   // push shape into output register
        logic       last;   // last-shape flag for emit
        logic [2:0] field;  // field code for step/store
    } t_rsg_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic cfg_bad;  // live config check
        logic bad;      // config check captured at load
        logic out_free; // output register can take a shape
    } t_rsg_sts;

    // Eight-entry RGB565 palette
    function automatic logic [15:0] rsg_palette(input logic [2:0] idx);
        logic [15:0] col;
        case (idx)
            3'd0:    col = 16'hF800; // red
            3'd1:    col = 16'hFD20; // orange
            3'd2:    col = 16'hFFE0; // yellow
            3'd3:    col = 16'h07E0; // green
            3'd4:    col = 16'h07FF; // cyan
            3'd5:    col = 16'h001F; // blue
            3'd6:    col = 16'h781F; // purple
            default: col = 16'hF81F; // pink
        endcase
        return col;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rsg_ctrl.sv @@
// Sequencing controller for the random shape generator.
// Walks each shape through generator steps, remainder iterations and output.
// Depends on rsg_pkg; drives rsg_dp through t_rsg_cmd.
`timescale 1ns / 1ps
`default_nettype none

module rsg_ctrl
    import rsg_pkg::*;
#(
    parameter int unsigned MAX_SHAPES = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_ready,
    input  wire logic [COUNT_W-1:0] i_count,
    input  wire t_rsg_sts           i_sts,
    output t_rsg_cmd                o_cmd
);

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SHAPES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_STEP  = 5'b00010,
        S_DIV   = 5'b00100,
        S_STORE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_left, n_left;
    logic [2:0]           r_field, n_field;
    logic [DIV_CNT_W-1:0] r_bit, n_bit;
    logic [COUNT_W-1:0]   sat_count;
    logic                 req_acc;

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;
    assign sat_count   = (i_count > MAX_CNT) ? MAX_CNT : i_count;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        n_field = r_field;
        n_bit   = r_bit;
        o_cmd   = '0;
        o_cmd.field = r_field;
        o_cmd.last  = (r_left == COUNT_W'(1));
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    o_cmd.load = 1'b1;
                    n_left  = sat_count;
                    n_field = FLD_KIND;
                    n_bit   = '0;
                    if (sat_count != '0) begin
                        n_state = i_sts.cfg_bad ? S_EMIT : S_STEP;
                    end
                end
            end
            S_STEP: begin
                // kind and colour need no remainder run
                o_cmd.step = 1'b1;
                n_state = ((r_field == FLD_KIND) || (r_field == FLD_COLOUR)) ?
                          S_STORE : S_DIV;
            end
            S_DIV: begin
                o_cmd.shift = 1'b1;
                n_bit = r_bit + 1'b1;
                if (r_bit == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_field == FLD_COLOUR) begin
                    n_state = S_EMIT;
                end else begin
                    n_field = r_field + 1'b1;
                    n_state = S_STEP;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_left  = r_left - 1'b1;
                    n_field = FLD_KIND;
                    if (r_left == COUNT_W'(1)) begin
                        n_state = S_IDLE;
                    end else if (!i_sts.bad) begin
                        n_state = S_STEP;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_field <= FLD_KIND;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_field <= n_field;
            r_bit   <= n_bit;
        end
    end

`ifndef SYNTHESIS
    // Between requests no shapes are pending
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> (r_left == '0))
        else $error("shapes pending while idle");

    // A nonzero request starts work on the next cycle
    a_req_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && (i_count != '0)) |=> !o_req_ready)
        else $error("nonzero request did not start");

    // Remainder bit counter is at zero outside the iteration
    a_bit_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> (r_bit == '0))
        else $error("bit counter not home");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/rsg_dp.sv @@
// Datapath of the random shape generator: config registers, LCG,
// bit-serial remainder unit, field registers and the output register.
// Depends on rsg_pkg; controlled by rsg_ctrl through t_rsg_cmd.
`timescale 1ns / 1ps
`default_nettype none

module rsg_dp
    import rsg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // seed from the request
    input  wire logic [SEED_W-1:0]     i_seed,
    input  wire t_rsg_cmd              i_cmd,
    output t_rsg_sts                   o_sts,
    // shape output
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [47:0]                o_m_tdata,
    output logic                       o_m_tuser,
    output logic                       o_m_tlast
);

    // Configuration registers
    logic [7:0] r_min_size, r_max_size;
    logic [9:0] r_screen_w, r_screen_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_size <= 8'd8;
            r_max_size <= 8'd40;
            r_screen_w <= 10'd320;
            r_screen_h <= 10'd240;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_SIZE:      r_min_size <= i_cfg_data[7:0];
                CFG_MAX_SIZE:      r_max_size <= i_cfg_data[7:0];
                CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Limit check
    logic cfg_bad;
    logic [9:0] max2;
    assign max2    = {1'b0, r_max_size, 1'b0};
    assign cfg_bad = (r_min_size > r_max_size) || (r_screen_w < max2) ||
                     (r_screen_h < max2);

    // Generator and captured check
    logic [31:0] r_gen, n_gen;
    logic        r_bad;
    assign n_gen = r_gen * LCG_MUL + LCG_INC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= '0;
            r_bad <= 1'b0;
        end else if (i_cmd.load) begin
            r_gen <= i_seed;
            r_bad <= cfg_bad;
        end else if (i_cmd.step) begin
            r_gen <= n_gen;
        end
    end

    // Span for the field being drawn; a zero size gives the screen extent plus one
    logic [7:0]  r_size;
    logic [10:0] size2, span;
    assign size2 = {2'b00, r_size, 1'b0};
    always_comb begin
        case (i_cmd.field)
            FLD_KIND: span = {1'b0, KIND_SPAN};
            FLD_SIZE: span = {3'b000, r_max_size} - {3'b000, r_min_size} + 11'd1;
            FLD_CX:   span = {1'b0, r_screen_w} - size2 + 11'd1;
            FLD_CY:   span = {1'b0, r_screen_h} - size2 + 11'd1;
            default:  span = {1'b0, KIND_SPAN};
        endcase
    end

    // Restoring remainder, one dividend bit per cycle
    logic [31:0] r_dividend;
    logic [10:0] r_span;
    logic [9:0]  r_rem;
    logic [10:0] rem_sh, rem_sub;
    assign rem_sh  = {r_rem, r_dividend[31]};
    assign rem_sub = rem_sh - r_span;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_dividend <= n_gen;
            r_span     <= span;
            r_rem      <= '0;
        end else if (i_cmd.shift) begin
            r_dividend <= {r_dividend[30:0], 1'b0};
            r_rem      <= (rem_sh >= r_span) ? rem_sub[9:0] : rem_sh[9:0];
        end
    end

    // Residue mod 3: 4 is 1 mod 3, so the base-4 digits are summed in a tree
    function automatic logic [1:0] mod3_32(input logic [31:0] x);
        logic [7:0][2:0] s1;
        logic [3:0][3:0] s2;
        logic [1:0][4:0] s3;
        logic [5:0]      s4;
        logic [3:0]      f1;
        logic [2:0]      f2;
        for (int i = 0; i < 8; i++) begin
            s1[i] = {1'b0, x[4*i +: 2]} + {1'b0, x[4*i+2 +: 2]};
        end
        for (int i = 0; i < 4; i++) begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        s4 = {1'b0, s3[0]} + {1'b0, s3[1]};
        f1 = {2'b00, s4[5:4]} + {2'b00, s4[3:2]} + {2'b00, s4[1:0]};
        f2 = {1'b0, f1[3:2]} + {1'b0, f1[1:0]};
        return (f2 >= 3'd3) ? 2'(f2 - 3'd3) : f2[1:0];
    endfunction

    // Field registers
    logic [1:0]  r_kind;
    logic [9:0]  r_cx, r_cy;
    logic [15:0] r_colour;
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            case (i_cmd.field)
                FLD_KIND:   r_kind   <= mod3_32(r_gen);
                FLD_SIZE:   r_size   <= r_min_size + r_rem[7:0];
                FLD_CX:     r_cx     <= {2'b00, r_size} + r_rem;
                FLD_CY:     r_cy     <= {2'b00, r_size} + r_rem;
                FLD_COLOUR: r_colour <= rsg_palette(r_gen[2:0]);
                default: ;
            endcase
        end
    end

    // Output register
    logic r_out_valid;
    logic [47:0] r_out_data;
    logic r_out_bad, r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_bad  <= r_bad;
            r_out_last <= i_cmd.last;
            r_out_data <= r_bad ? '0 :
                          {2'b00, r_colour, r_cy, r_cx, r_size, r_kind};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_bad;
    assign o_m_tlast  = r_out_last;

    assign o_sts.cfg_bad  = cfg_bad;
    assign o_sts.bad      = r_bad;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

`ifndef SYNTHESIS
    // A shape is only pushed when the output register frees up
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_m_tready))
        else $error("output register overwritten");

    // Shapes under a bad configuration carry zero fields
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("bad-config shape not zeroed");

    // A stalled shape stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) &&
                                          $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("stalled shape changed");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/random_shape_generator_core.sv @@
// Top level of the random shape generator.
// Instantiates rsg_ctrl and rsg_dp; uses rsg_pkg.
//
//   channel  dir  handshake                 payload
//   s        in   i_s_tvalid / o_s_tready   tdata: seed_value, shape_count
//   m        out  o_m_tvalid / i_m_tready   tdata: shape fields; tuser, tlast
//   cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each shape takes a step, a bit-serial remainder run and a store for size, centre x and
// centre y, and a step and a store each for kind and colour, then an output emit.
// Under a bad configuration each shape goes straight to the output emit.
// Reset is synchronous, active low, and restores the default limits.
// A stalled output holds the shape in the output register and pauses the sequence.
// A new request is taken once the last shape of the previous one is registered.
`timescale 1ns / 1ps
`default_nettype none

module random_shape_generator_core
    import rsg_pkg::*;
#(
    parameter int unsigned MAX_SHAPES = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [39:0]           i_s_tdata,   // seed_value[31:0], shape_count[38:32]
    // shape stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [47:0]                o_m_tdata,   // shape_kind[1:0], shape_size[9:2],
                                                    // centre_x[19:10], centre_y[29:20],
                                                    // colour_rgb565[45:30]
    output logic                       o_m_tuser,   // bad_config
    output logic                       o_m_tlast,   // last_shape
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_rsg_cmd cmd;
    t_rsg_sts sts;

    // Config registers always take a beat
    assign o_cfg_ready = 1'b1;

    rsg_ctrl #(
        .MAX_SHAPES (MAX_SHAPES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_count     (i_s_tdata[38:32]),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rsg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_seed      (i_s_tdata[31:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_random_shape_generator_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for random_shape_generator_core: seeded shape requests,
// limit register writes, and a per-beat check against an in-bench shape predictor.
// Depends on rsg_pkg and the random_shape_generator_core RTL.

module tb_random_shape_generator_core;
    import rsg_pkg::*;

    localparam int unsigned SHAPE_LIMIT    = 64;
    localparam int unsigned SETTLE_CYCLES  = 300;   // longer than one shape
    localparam int unsigned RANDOM_PHASES  = 5;
    localparam int unsigned REQS_PER_PHASE = 17;
    localparam longint      RUN_LIMIT_NS   = 48_000_000;

    // Unused register indexes, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    // RGB565 colors, entry 0 in the low bits
    localparam logic [8*16-1:0] COLOR_TABLE = {
        16'hF81F, 16'h781F, 16'h001F, 16'h07FF,
        16'h07E0, 16'hFFE0, 16'hFD20, 16'hF800
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  size;
        logic [9:0]  cx;
        logic [9:0]  cy;
        logic [15:0] colour;
        logic        bad;
        logic        last;
    } t_shape;

    // Shape predictor plus the queue of shapes still owed by the block
    class shape_list_checker;
        int unsigned min_size, max_size, scr_width, scr_height;
        logic [31:0] lcg_state;
        t_shape      expected_shapes[$];
        int unsigned errors;
        int unsigned beat_count;

        function new();
            min_size   = 8;
            max_size   = 40;
            scr_width  = 320;
            scr_height = 240;
            lcg_state  = '0;
            errors     = 0;
            beat_count = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] ERROR: %s", $time, msg);
        endtask

        function void note_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_SIZE:      min_size   = data[7:0];
                CFG_MAX_SIZE:      max_size   = data[7:0];
                CFG_SCREEN_WIDTH:  scr_width  = data;
                CFG_SCREEN_HEIGHT: scr_height = data;
                default: ;
            endcase
        endfunction

        function int unsigned next_value();
            lcg_state = lcg_state * LCG_MUL + LCG_INC;
            return lcg_state;
        endfunction

        // Builds the whole shape list of one accepted request
        function void note_request(logic [31:0] seed, logic [6:0] count);
            int unsigned n;
            int unsigned sz;
            int unsigned pick;
            bit          bad;
            t_shape      s;
            lcg_state = seed;
            n = (count > SHAPE_LIMIT) ? SHAPE_LIMIT : count;
            bad = (min_size > max_size) || (scr_width < 2 * max_size) ||
                  (scr_height < 2 * max_size);
            for (int unsigned i = 0; i < n; i++) begin
                s = '0;
                // bad limits: zeroed fields, generator left at the seed
                if (!bad) begin
                    s.kind = 2'(next_value() % KIND_SPAN);
                    sz = min_size + next_value() % (max_size - min_size + 1);
                    s.size = 8'(sz);
                    s.cx = 10'(sz + next_value() % (scr_width - 2 * sz + 1));
                    s.cy = 10'(sz + next_value() % (scr_height - 2 * sz + 1));
                    pick = next_value() & 7;
                    s.colour = COLOR_TABLE[pick*16 +: 16];
                end
                s.bad  = bad;
                s.last = (i == n - 1);
                expected_shapes = {expected_shapes, s};
            end
        endfunction

        task compare_field(string field_name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("shape %0d %s: got 0x%0h, expected 0x%0h",
                                          beat_count, field_name, got, want));
        endtask

        task check_shape(logic [47:0] data, logic bad, logic last);
            t_shape e;
            if (expected_shapes.size() == 0) begin
                report_mismatch($sformatf("shape %0d arrived with none expected", beat_count));
            end else begin
                e = expected_shapes.pop_front();
                compare_field("kind",   data[1:0],   e.kind);
                compare_field("size",   data[9:2],   e.size);
                compare_field("cx",     data[19:10], e.cx);
                compare_field("cy",     data[29:20], e.cy);
                compare_field("colour", data[45:30], e.colour);
                compare_field("bad",    bad,         e.bad);
                compare_field("last",   last,        e.last);
            end
            beat_count++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [39:0]           i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [47:0]           o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bit gaps_on;

    shape_list_checker shape_check = new();

    random_shape_generator_core #(
        .MAX_SHAPES (SHAPE_LIMIT)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Check every accepted shape beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            shape_check.check_shape(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // Shape sink: random stall before each beat while gaps are on
    initial begin : shape_sink
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = gaps_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    // One request beat; valid stays high for a back-to-back follower
    task automatic send_request(input logic [31:0] seed, input logic [6:0] count);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, count, seed};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        shape_check.note_request(seed, count);
    endtask

    // Drop valid and wait for every owed shape
    task automatic wait_shapes_done();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (shape_check.expected_shapes.size() != 0) @(posedge i_clk);
    endtask

    // Idle point: also covers a zero-count request still in flight
    task automatic settle_idle();
        wait_shapes_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shape_check.note_limit(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [9:0] min_sz, input logic [9:0] max_sz,
                              input logic [9:0] width, input logic [9:0] height);
        write_limit(CFG_MIN_SIZE, min_sz);
        write_limit(CFG_MAX_SIZE, max_sz);
        write_limit(CFG_SCREEN_WIDTH, width);
        write_limit(CFG_SCREEN_HEIGHT, height);
    endtask

    // Run limit
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int unsigned sz_min;
        int unsigned sz_max;
        logic [6:0]  count;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        gaps_on     = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default limits: seed extremes, zero count, full and saturated counts
        send_request(32'h0000_0000, 7'd1);
        send_request(32'hFFFF_FFFF, 7'd2);
        send_request(32'h1234_5678, 7'd0);
        send_request(32'hDEAD_BEEF, 7'd64);
        send_request(32'h5A5A_5A5A, 7'd127);
        send_request(32'h0000_0001, 7'd65);

        // Widest size range; upper data bits of the 8-bit limits must be dropped
        settle_idle();
        set_limits(10'h001, 10'h3FF, 10'h3FF, 10'h3FF);
        send_request(32'hFFFF_FFFF, 7'd3);
        send_request(32'h0000_0000, 7'd2);

        // Largest size on the smallest screen that fits it: centre pinned
        settle_idle();
        set_limits(10'd255, 10'd255, 10'd510, 10'd510);
        send_request(32'hCAFE_F00D, 7'd4);

        // Smallest size and screen
        settle_idle();
        set_limits(10'd1, 10'd1, 10'd2, 10'd2);
        send_request(32'h8000_0001, 7'd4);

        // Bad limits: min above max
        settle_idle();
        set_limits(10'd200, 10'd100, 10'd1023, 10'd1023);
        send_request(32'h0BAD_C0DE, 7'd3);
        send_request(32'h7777_7777, 7'd0);
        send_request(32'h2468_ACE0, 7'd127);

        // Bad limits: screen too narrow, then too short
        settle_idle();
        set_limits(10'd8, 10'd40, 10'd79, 10'd240);
        send_request(32'h1357_9BDF, 7'd2);
        settle_idle();
        set_limits(10'd8, 10'd40, 10'd240, 10'd79);
        send_request(32'hFEDC_BA98, 7'd2);

        // Writes to unused indexes leave the limits alone
        settle_idle();
        set_limits(10'd8, 10'd40, 10'd320, 10'd240);
        write_limit(CFG_IDX_SPARE_LO, 10'h155);
        write_limit(CFG_IDX_SPARE_HI, 10'h2AA);
        send_request(32'h0F0F_F0F0, 7'd3);

        // Random phases, each with fresh limits; one phase with no idling
        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            settle_idle();
            gaps_on = (p != 1);
            if (p == 2) begin
                // anything goes, mostly inconsistent
                set_limits(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                           10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)));
            end else begin
                sz_max = $urandom_range(1, 255);
                sz_min = $urandom_range(1, sz_max);
                set_limits({2'($urandom_range(0, 3)), 8'(sz_min)},
                           {2'($urandom_range(0, 3)), 8'(sz_max)},
                           10'($urandom_range(2 * sz_max, 1023)),
                           10'($urandom_range(2 * sz_max, 1023)));
            end
            if (p == 3)
                write_limit(3'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                            10'($urandom));
            for (int unsigned i = 0; i < REQS_PER_PHASE; i++) begin
                // halfway through, let the output side drain completely
                if (i == REQS_PER_PHASE / 2)
                    wait_shapes_done();
                // mostly short lists, a few long or saturated ones
                count = ($urandom_range(0, 99) < 5) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(0, 8));
                send_request($urandom, count);
            end
        end

        settle_idle();
        if (shape_check.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
